[rtl/core/spa_pkg.sv]
package spa_pkg;

    // Sizing of the stores
    localparam int MAX_SLABS  = 64;
    localparam int ADDR_BITS  = 24;
    localparam int IDX_BITS   = $clog2(MAX_SLABS);
    localparam int CNT_BITS   = $clog2(MAX_SLABS + 1);

    // Field widths
    localparam int PAYLOAD_W  = 16;
    localparam int SPR_W      = 7;
    localparam int HEAP_W     = 24;
    localparam int STRIDE_W   = 17;
    localparam int TOTAL_W    = SPR_W + STRIDE_W;
    localparam int TSIZE_W    = HEAP_W + 1;
    localparam int STATUS_W   = 2;
    localparam int REQ_W      = 2;
    localparam int COUNT_W    = 7;

    localparam int HDR_BYTES   = 12;
    localparam int ALIGN_BYTES = 32;

    // Configuration register reset values
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_RST = PAYLOAD_W'(256);
    localparam logic [SPR_W-1:0]     SPR_RST     = SPR_W'(8);
    localparam logic [HEAP_W-1:0]    HEAP_RST    = HEAP_W'(65536);

    // Configuration register index (paddr word select)
    localparam logic [1:0] REG_PAYLOAD = 2'd0;
    localparam logic [1:0] REG_SPR     = 2'd1;
    localparam logic [1:0] REG_HEAP    = 2'd2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SLAB_FREE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE      = 2'd2;
    localparam logic [REQ_W-1:0] REQ_INIT      = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic                 we;
        logic [IDX_BITS-1:0]  waddr;
        logic [ADDR_BITS-1:0] wdata;
        logic [IDX_BITS-1:0]  raddr;
    } t_ram_ctl;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_BITS-1:0] slab_address;
        logic [ADDR_BITS-1:0] block_offset;
        logic [STRIDE_W-1:0]  block_size;
        logic [COUNT_W-1:0]   ready_count;
        logic [COUNT_W-1:0]   taken_count;
    } t_result;

endpackage

[rtl/core/spa_ram.sv]
module spa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/spa_engine.sv]
module spa_engine
    import spa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [STRIDE_W-1:0]  i_stride,
    input  logic [SPR_W-1:0]     i_spr,
    input  logic [HEAP_W-1:0]    i_heap,
    input  logic                 i_out_free,
    output logic                 o_idle,
    output logic                 o_done,
    output t_result              o_result,
    output t_ram_ctl             o_ready_ram,
    input  logic [ADDR_BITS-1:0] i_ready_rdata,
    output t_ram_ctl             o_taken_ram,
    input  logic [ADDR_BITS-1:0] i_taken_rdata
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_MUL    = 10'b0000000010,
        S_CHK    = 10'b0000000100,
        S_CARVE  = 10'b0000001000,
        S_POP_RD = 10'b0000010000,
        S_POP_WR = 10'b0000100000,
        S_SCAN   = 10'b0001000000,
        S_SHIFT  = 10'b0010000000,
        S_PUSH   = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    localparam logic [CNT_BITS-1:0]  MAX_CNT = CNT_BITS'(MAX_SLABS);
    localparam logic [ADDR_BITS-1:0] HDR_A   = ADDR_BITS'(HDR_BYTES);

    t_state                r_state;
    logic [REQ_W-1:0]      r_req;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [STATUS_W-1:0]   r_status;
    logic [ADDR_BITS-1:0]  r_slab_addr;
    logic [CNT_BITS-1:0]   r_ready_depth;
    logic [CNT_BITS-1:0]   r_taken_depth;
    logic [ADDR_BITS-1:0]  r_tail_off;
    logic [TSIZE_W-1:0]    r_tail_size;
    logic [TOTAL_W-1:0]    r_total;
    logic [SPR_W-1:0]      r_cnt;
    logic [CNT_BITS-1:0]   r_idx;
    logic                  r_pend;
    logic [IDX_BITS-1:0]   r_pidx;
    logic                  r_list_rdy;

    logic [CNT_BITS-1:0]   sel_depth;
    logic [ADDR_BITS-1:0]  sel_rdata;
    logic                  issue;
    logic                  free_ok;

    assign sel_depth = r_list_rdy ? r_ready_depth : r_taken_depth;
    assign sel_rdata = r_list_rdy ? i_ready_rdata : i_taken_rdata;
    assign issue     = (r_idx < sel_depth);

    // RAM port steering
    always_comb begin
        o_ready_ram       = '0;
        o_taken_ram       = '0;
        unique case (r_state) inside
            S_CARVE: begin
                o_ready_ram.we    = (r_cnt != '0);
                o_ready_ram.waddr = r_ready_depth[IDX_BITS-1:0];
                o_ready_ram.wdata = r_tail_off + HDR_A;
            end
            S_POP_RD: begin
                o_ready_ram.raddr = IDX_BITS'(r_ready_depth - 1'b1);
            end
            S_POP_WR: begin
                o_taken_ram.we    = 1'b1;
                o_taken_ram.waddr = r_taken_depth[IDX_BITS-1:0];
                o_taken_ram.wdata = i_ready_rdata;
            end
            S_SCAN, S_SHIFT: begin
                if (r_list_rdy) begin
                    o_ready_ram.raddr = r_idx[IDX_BITS-1:0];
                    o_ready_ram.we    = (r_state == S_SHIFT) && r_pend;
                    o_ready_ram.waddr = r_pidx - 1'b1;
                    o_ready_ram.wdata = i_ready_rdata;
                end else begin
                    o_taken_ram.raddr = r_idx[IDX_BITS-1:0];
                    o_taken_ram.we    = (r_state == S_SHIFT) && r_pend;
                    o_taken_ram.waddr = r_pidx - 1'b1;
                    o_taken_ram.wdata = i_taken_rdata;
                end
            end
            S_PUSH: begin
                o_ready_ram.we    = 1'b1;
                o_ready_ram.waddr = r_ready_depth[IDX_BITS-1:0];
                o_ready_ram.wdata = r_addr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ready_depth <= '0;
            r_taken_depth <= '0;
            r_tail_off    <= '0;
            r_tail_size   <= '0;
            r_pend        <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req       <= i_req_type;
                        r_addr      <= i_address;
                        r_status    <= ST_OK;
                        r_slab_addr <= '0;
                        r_idx       <= '0;
                        r_pend      <= 1'b0;
                        r_list_rdy  <= 1'b0;
                        unique case (i_req_type) inside
                            REQ_ALLOC: begin
                                if (r_taken_depth >= MAX_CNT) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else if (r_ready_depth != '0) begin
                                    r_state <= S_POP_RD;
                                end else if (i_spr == '0) begin
                                    r_status <= ST_EXHAUSTED;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_MUL;
                                end
                            end
                            REQ_SLAB_FREE, REQ_FREE: begin
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_ready_depth <= '0;
                                r_taken_depth <= '0;
                                r_tail_off    <= '0;
                                r_tail_size   <= {1'b0, i_heap};
                                r_state       <= S_MUL;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    // refill is all or nothing: room on the stack first
                    r_total <= TOTAL_W'(i_spr) * TOTAL_W'(i_stride);
                    r_cnt   <= i_spr;
                    if (32'(i_spr) > 32'(MAX_CNT - r_ready_depth)) begin
                        r_status <= ST_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (TSIZE_W'(r_total) > r_tail_size) begin
                        r_status <= ST_EXHAUSTED;
                        r_state  <= S_DONE;
                    end else begin
                        r_tail_size <= r_tail_size - TSIZE_W'(r_total);
                        r_state     <= S_CARVE;
                    end
                end
                S_CARVE: begin
                    if (r_cnt != '0) begin
                        r_cnt         <= r_cnt - 1'b1;
                        r_ready_depth <= r_ready_depth + 1'b1;
                        r_tail_off    <= r_tail_off + ADDR_BITS'(i_stride);
                    end else if (r_req == REQ_ALLOC) begin
                        r_state <= S_POP_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_POP_RD: begin
                    r_state <= S_POP_WR;
                end
                S_POP_WR: begin
                    r_slab_addr   <= i_ready_rdata;
                    r_ready_depth <= r_ready_depth - 1'b1;
                    r_taken_depth <= r_taken_depth + 1'b1;
                    r_state       <= S_DONE;
                end
                S_SCAN: begin
                    if (r_pend && (sel_rdata == r_addr)) begin
                        if ((r_req == REQ_SLAB_FREE) && (r_ready_depth >= MAX_CNT)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_idx   <= CNT_BITS'(r_pidx) + 1'b1;
                            r_pend  <= 1'b0;
                            r_state <= S_SHIFT;
                        end
                    end else if (!r_pend && !issue) begin
                        if ((r_req == REQ_FREE) && !r_list_rdy) begin
                            r_list_rdy <= 1'b1;
                            r_idx      <= '0;
                        end else begin
                            r_status <= ST_NOT_FOUND;
                            r_state  <= S_DONE;
                        end
                    end else begin
                        r_pend <= issue;
                        r_pidx <= r_idx[IDX_BITS-1:0];
                        if (issue) begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_SHIFT: begin
                    // close the gap: read entry i+1, write it at i next cycle
                    if (!r_pend && !issue) begin
                        if (r_list_rdy) begin
                            r_ready_depth <= r_ready_depth - 1'b1;
                        end else begin
                            r_taken_depth <= r_taken_depth - 1'b1;
                        end
                        r_state <= (r_req == REQ_SLAB_FREE) ? S_PUSH : S_DONE;
                    end else begin
                        r_pend <= issue;
                        r_pidx <= r_idx[IDX_BITS-1:0];
                        if (issue) begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_PUSH: begin
                    r_ready_depth <= r_ready_depth + 1'b1;
                    r_state       <= S_DONE;
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign free_ok = (r_req == REQ_FREE) && (r_status == ST_OK);

    assign o_idle                = (r_state == S_IDLE);
    assign o_done                = (r_state == S_DONE) && i_out_free;
    assign o_result.status       = r_status;
    assign o_result.slab_address = r_slab_addr;
    assign o_result.block_offset = free_ok ? (r_addr - HDR_A) : '0;
    assign o_result.block_size   = free_ok ? i_stride : '0;
    assign o_result.ready_count  = COUNT_W'(r_ready_depth);
    assign o_result.taken_count  = COUNT_W'(r_taken_depth);

endmodule

[rtl/core/slab_pool_allocator.sv]
// Slab pool allocator: LIFO ready stack and ordered taken list in two RAMs.
// Slab alloc pops the ready stack, refilling it first when the stack is empty;
// initialize empties both lists and carves a fresh refill; slab free and free walk
// a list one RAM read per cycle, and a free may fall through to the ready stack.
// One transaction at a time. Sync reset empties both lists.
module slab_pool_allocator
    import spa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [ADDR_BITS-1:0] i_address,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [ADDR_BITS-1:0] o_slab_address,
    output logic [ADDR_BITS-1:0] o_block_offset,
    output logic [STRIDE_W-1:0]  o_block_size,
    output logic [COUNT_W-1:0]   o_ready_count,
    output logic [COUNT_W-1:0]   o_taken_count,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [STRIDE_W:0] ALIGN_MASK = ~((STRIDE_W + 1)'(ALIGN_BYTES - 1));

    logic [PAYLOAD_W-1:0] r_payload;
    logic [SPR_W-1:0]     r_spr;
    logic [HEAP_W-1:0]    r_heap;

    logic                 r_out_valid;
    t_result              r_out;

    logic                 cfg_wr;
    logic [STRIDE_W:0]    hdr_sum;
    logic [STRIDE_W:0]    rounded;
    logic [STRIDE_W-1:0]  stride;

    logic                 eng_idle;
    logic                 eng_done;
    logic                 out_free;
    t_result              eng_result;
    t_ram_ctl             ready_ctl;
    t_ram_ctl             taken_ctl;
    logic [ADDR_BITS-1:0] ready_rdata;
    logic [ADDR_BITS-1:0] taken_rdata;

    // APB: zero-wait, write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload <= PAYLOAD_RST;
            r_spr     <= SPR_RST;
            r_heap    <= HEAP_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_PAYLOAD: r_payload <= pwdata[PAYLOAD_W-1:0];
                REG_SPR:     r_spr     <= pwdata[SPR_W-1:0];
                REG_HEAP:    r_heap    <= pwdata[HEAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PAYLOAD: prdata = 32'(r_payload);
            REG_SPR:     prdata = 32'(r_spr);
            REG_HEAP:    prdata = 32'(r_heap);
            default:     prdata = '0;
        endcase
    end

    // Slab stride: payload plus header, rounded up to the alignment
    assign hdr_sum = (STRIDE_W + 1)'(r_payload) + (STRIDE_W + 1)'(HDR_BYTES);
    assign rounded = (hdr_sum + (STRIDE_W + 1)'(ALIGN_BYTES - 1)) & ALIGN_MASK;
    assign stride  = rounded[STRIDE_W-1:0];

    // Output register: engine may finish while the slot drains
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = eng_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done) begin
            r_out <= eng_result;
        end
    end

    spa_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_in_valid && eng_idle),
        .i_req_type    (i_req_type),
        .i_address     (i_address),
        .i_stride      (stride),
        .i_spr         (r_spr),
        .i_heap        (r_heap),
        .i_out_free    (out_free),
        .o_idle        (eng_idle),
        .o_done        (eng_done),
        .o_result      (eng_result),
        .o_ready_ram   (ready_ctl),
        .i_ready_rdata (ready_rdata),
        .o_taken_ram   (taken_ctl),
        .i_taken_rdata (taken_rdata)
    );

    // Ready stack (LIFO of slab data addresses)
    spa_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (MAX_SLABS)
    ) u_ready_ram (
        .i_clk   (i_clk),
        .i_we    (ready_ctl.we),
        .i_waddr (ready_ctl.waddr),
        .i_wdata (ready_ctl.wdata),
        .i_raddr (ready_ctl.raddr),
        .o_rdata (ready_rdata)
    );

    // Taken list (ordered, compacted on removal)
    spa_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (MAX_SLABS)
    ) u_taken_ram (
        .i_clk   (i_clk),
        .i_we    (taken_ctl.we),
        .i_waddr (taken_ctl.waddr),
        .i_wdata (taken_ctl.wdata),
        .i_raddr (taken_ctl.raddr),
        .o_rdata (taken_rdata)
    );

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_slab_address = r_out.slab_address;
    assign o_block_offset = r_out.block_offset;
    assign o_block_size   = r_out.block_size;
    assign o_ready_count  = r_out.ready_count;
    assign o_taken_count  = r_out.taken_count;

endmodule

[dv/slab_sb_pkg.sv]
package slab_sb_pkg;
    import spa_pkg::*;

    typedef logic [ADDR_BITS-1:0] t_addr;

    // Slab pool predictor plus the queue of results it still owes.
    class slab_scoreboard;
        logic [PAYLOAD_W-1:0] payload_cfg;
        logic [SPR_W-1:0]     refill_cfg;
        logic [HEAP_W-1:0]    heap_cfg;
        t_addr                ready_stack[$];
        t_addr                taken_list[$];
        t_addr                tail_offset;
        logic [TSIZE_W-1:0]   tail_size;
        t_result              expected_q[$];
        int                   errors;
        int                   results_checked;
        int                   req_hits[4];
        int                   status_hits[4];

        function new();
            payload_cfg     = PAYLOAD_RST;
            refill_cfg      = SPR_RST;
            heap_cfg        = HEAP_RST;
            tail_offset     = '0;
            tail_size       = '0;
            errors          = 0;
            results_checked = 0;
        endfunction

        function void set_config(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_PAYLOAD: payload_cfg = value[PAYLOAD_W-1:0];
                REG_SPR:     refill_cfg  = value[SPR_W-1:0];
                REG_HEAP:    heap_cfg    = value[HEAP_W-1:0];
                default:     ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Payload plus header, rounded up to the alignment.
        function logic [STRIDE_W-1:0] slab_stride();
            int unsigned span;
            span = payload_cfg + HDR_BYTES;
            return STRIDE_W'((span + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES);
        endfunction

        // All or nothing: room on the stack first, then room in the tail.
        function logic [STATUS_W-1:0] carve_slabs();
            logic [STRIDE_W-1:0] stride;
            logic [TSIZE_W-1:0]  span;
            stride = slab_stride();
            span   = refill_cfg * stride;
            if (int'(refill_cfg) > MAX_SLABS - ready_stack.size())
                return ST_FULL;
            if (span > tail_size)
                return ST_EXHAUSTED;
            repeat (refill_cfg) begin
                ready_stack.insert(ready_stack.size(), tail_offset + t_addr'(HDR_BYTES));
                tail_offset += stride;
            end
            tail_size -= span;
            return ST_OK;
        endfunction

        function int position_of(ref t_addr list[$], input t_addr addr);
            foreach (list[i])
                if (list[i] == addr)
                    return i;
            return -1;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, t_addr addr);
            t_result r;
            int      pos;
            r = '0;
            req_hits[req]++;
            case (req)
                REQ_ALLOC: begin
                    if (taken_list.size() >= MAX_SLABS) begin
                        r.status = ST_FULL;
                    end else begin
                        if (ready_stack.size() == 0)
                            r.status = (refill_cfg == 0) ? ST_EXHAUSTED : carve_slabs();
                        if (r.status == ST_OK) begin
                            r.slab_address = ready_stack[$];
                            ready_stack.delete(ready_stack.size() - 1);
                            taken_list.insert(taken_list.size(), r.slab_address);
                        end
                    end
                end
                REQ_SLAB_FREE: begin
                    pos = position_of(taken_list, addr);
                    if (pos < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else if (ready_stack.size() >= MAX_SLABS) begin
                        r.status = ST_FULL;
                    end else begin
                        taken_list.delete(pos);
                        ready_stack.insert(ready_stack.size(), addr);
                    end
                end
                REQ_FREE: begin
                    pos = position_of(taken_list, addr);
                    if (pos >= 0) begin
                        taken_list.delete(pos);
                    end else begin
                        pos = position_of(ready_stack, addr);
                        if (pos >= 0)
                            ready_stack.delete(pos);
                        else
                            r.status = ST_NOT_FOUND;
                    end
                    if (r.status == ST_OK) begin
                        r.block_offset = addr - t_addr'(HDR_BYTES);
                        r.block_size   = slab_stride();
                    end
                end
                REQ_INIT: begin
                    ready_stack.delete();
                    taken_list.delete();
                    tail_offset = '0;
                    tail_size   = heap_cfg;
                    r.status    = carve_slabs();
                end
            endcase
            r.ready_count = COUNT_W'(ready_stack.size());
            r.taken_count = COUNT_W'(taken_list.size());
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                         $time, name, want, want, got, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, status %0d slab 0x%0h block 0x%0h",
                         $time, got.status, got.slab_address, got.block_offset);
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            status_hits[want.status]++;
            check_field("status", want.status, got.status);
            check_field("slab_address", want.slab_address, got.slab_address);
            check_field("block_offset", want.block_offset, got.block_offset);
            check_field("block_size", want.block_size, got.block_size);
            check_field("ready_count", want.ready_count, got.ready_count);
            check_field("taken_count", want.taken_count, got.taken_count);
        endfunction
    endclass

endpackage

[dv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spa_pkg::*;
    import slab_sb_pkg::*;

    // Quiet cycles tolerated: the worst free walk plus the long hold-off,
    // with plenty of margin.
    localparam int WATCHDOG_CYCLES = 10000;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int DRAIN_CYCLES    = 200;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_ready;
    logic [REQ_W-1:0]     i_req_type   = REQ_ALLOC;
    logic [ADDR_BITS-1:0] i_address    = '0;
    logic                 o_out_valid;
    logic                 i_out_ready  = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [ADDR_BITS-1:0] o_slab_address;
    logic [ADDR_BITS-1:0] o_block_offset;
    logic [STRIDE_W-1:0]  o_block_size;
    logic [COUNT_W-1:0]   o_ready_count;
    logic [COUNT_W-1:0]   o_taken_count;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [3:0]           paddr        = '0;
    logic [31:0]          pwdata       = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Idle knobs for the current phase (percent of cycles).
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic rx_hold      = 1'b0;
    int   quiet_cycles = 0;

    slab_scoreboard sb = new();

    slab_pool_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_address      (i_address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_slab_address (o_slab_address),
        .o_block_offset (o_block_offset),
        .o_block_size   (o_block_size),
        .o_ready_count  (o_ready_count),
        .o_taken_count  (o_taken_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side: check every accepted transaction, then pick next cycle's
    // ready. A long hold-off from the main thread overrides the random stall.
    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = '{status: o_status, slab_address: o_slab_address,
                     block_offset: o_block_offset, block_size: o_block_size,
                     ready_count: o_ready_count, taken_count: o_taken_count};
            sb.check_result(seen);
        end
        i_out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog: any transaction on either channel resets the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: watchdog expired, no transaction for %0d cycles",
                     $time, WATCHDOG_CYCLES);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request, with random idle cycles ahead of it, and hold it
    // until accepted. Valid stays high on return so a follow-on request can
    // go out back to back; whoever stops sending must drop it.
    task automatic send_request(logic [REQ_W-1:0] req, t_addr addr);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_address  <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req, addr);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // APB write, then read the register back.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] got;
        case (idx)
            REG_PAYLOAD: mask = ~(32'hFFFF_FFFF << PAYLOAD_W);
            REG_SPR:     mask = ~(32'hFFFF_FFFF << SPR_W);
            REG_HEAP:    mask = ~(32'hFFFF_FFFF << HEAP_W);
            default:     mask = '0;
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // register takes the value at this edge; go straight to a read setup
        sb.set_config(idx, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got != (value & mask)) begin
            sb.errors++;
            $display("%0t: register %0d readback, expected 0x%0h, got 0x%0h",
                     $time, idx, value & mask, got);
        end
    endtask

    task automatic configure(int payload, int refill, int heap);
        wait_drained();
        write_reg(REG_PAYLOAD, payload);
        write_reg(REG_SPR, refill);
        write_reg(REG_HEAP, heap);
    endtask

    // New settings, new idle pattern, then an initialize to carve the pool.
    task automatic start_phase(int payload, int refill, int heap, int tx_pct, int rx_pct);
        configure(payload, refill, heap);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        send_request(REQ_INIT, t_addr'($urandom));
    endtask

    // Mostly addresses that live in a list, some pure noise. Slab free looks
    // in the taken list only, so prefer taken addresses for it.
    function automatic t_addr pick_address(bit any_list);
        int r;
        int nt;
        int nr;
        r  = $urandom_range(99);
        nt = sb.taken_list.size();
        nr = sb.ready_stack.size();
        if (r < 15 || nt + nr == 0)
            return t_addr'($urandom);
        if (nt > 0 && (!any_list || r < 60 || nr == 0))
            return sb.taken_list[$urandom_range(nt - 1)];
        return sb.ready_stack[$urandom_range(nr - 1)];
    endfunction

    task automatic random_items(int count, int alloc_pct);
        logic [REQ_W-1:0] req;
        int               r;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < alloc_pct) begin
                req = REQ_ALLOC;
            end else begin
                r   = $urandom_range(99);
                req = (r < 46) ? REQ_SLAB_FREE : (r < 94) ? REQ_FREE : REQ_INIT;
            end
            if (req == REQ_SLAB_FREE || req == REQ_FREE)
                send_request(req, pick_address(req == REQ_FREE));
            else
                send_request(req, t_addr'($urandom));
        end
    endtask

    // Drive the taken list to its limit, then refill with one free slot so
    // the ready stack ends up full and a slab free bounces off it.
    task automatic fill_and_overflow();
        for (int k = 0; k < MAX_SLABS && sb.taken_list.size() < MAX_SLABS; k++)
            send_request(REQ_ALLOC, t_addr'($urandom));
        send_request(REQ_ALLOC, t_addr'($urandom));
        send_request(REQ_FREE, sb.taken_list[$urandom_range(sb.taken_list.size() - 1)]);
        send_request(REQ_ALLOC, t_addr'($urandom));
        send_request(REQ_SLAB_FREE, sb.taken_list[$urandom_range(sb.taken_list.size() - 1)]);
        send_request(REQ_SLAB_FREE, sb.taken_list[$urandom_range(sb.taken_list.size() - 1)]);
    endtask

    task automatic directed_items();
        t_addr a;
        // reset settings, nothing carved yet: alloc finds an empty tail
        send_request(REQ_ALLOC, '0);
        send_request(REQ_SLAB_FREE, '0);
        send_request(REQ_FREE, '1);
        send_request(REQ_INIT, '0);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_ALLOC, '1);
        send_request(REQ_ALLOC, '0);
        // take from the middle of each list so order keeping shows up
        send_request(REQ_SLAB_FREE, sb.taken_list[1]);
        send_request(REQ_FREE, sb.taken_list[0]);
        a = sb.ready_stack[2];
        send_request(REQ_FREE, a);
        send_request(REQ_FREE, a);
        send_request(REQ_SLAB_FREE, sb.ready_stack[0]);
        send_request(REQ_SLAB_FREE, '1);
        // zero refill count: initialize carves nothing, alloc runs dry
        configure(0, 0, HEAP_RST);
        send_request(REQ_INIT, '1);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, '0);
        // refill count beyond the stack depth: table full
        configure(16'hFFFF, 7'h7F, 24'hFF_FFFF);
        send_request(REQ_INIT, '0);
        send_request(REQ_ALLOC, '0);
        // largest stride, one slab per refill
        configure(16'hFFFF, 1, 24'hFF_FFFF);
        send_request(REQ_INIT, '0);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, sb.taken_list[0]);
        // heap too small for even one refill
        configure(16'hFFFF, 2, 100);
        send_request(REQ_INIT, '0);
        send_request(REQ_ALLOC, '0);
    endtask

    initial begin
        int refill;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_items();

        // Phase: moderate pools, no idling on either side.
        start_phase($urandom_range(400), $urandom_range(1, 16), HEAP_RST, 0, 0);
        random_items(100, 55);

        // Phase: 64 slabs per refill, sender idle half the time; push both
        // lists to their limits.
        start_phase($urandom_range(64), MAX_SLABS, 1 << 20, 50, 0);
        fill_and_overflow();
        random_items(80, 50);

        // Phase: tiny heap so refills run out, receiver stalls half the time.
        start_phase($urandom_range(200), $urandom_range(1, 4), $urandom_range(200, 3000),
                    0, 50);
        random_items(100, 65);

        // Phase: huge strides over the largest heap, light idling both sides.
        start_phase($urandom_range(16'hFFFF), $urandom_range(1, 3), 24'hFF_FFFF, 15, 15);
        random_items(60, 50);

        // Phase: hold the result side off for a long stretch while requests
        // keep coming, then let the sender pause until all results are in.
        start_phase($urandom_range(100), $urandom_range(8, 32), HEAP_RST, 0, 0);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        random_items(30, 50);
        wait_drained();
        random_items(30, 50);

        // Phase: random settings, occasionally an out-of-range refill count.
        refill = ($urandom_range(99) < 10) ? $urandom_range(127) : $urandom_range(1, 64);
        start_phase($urandom_range(2000), refill, $urandom_range(24'hFF_FFFF), 15, 15);
        random_items(120, 45);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: %0d alloc, %0d slab free, %0d free, %0d initialize.",
                 sb.req_hits[REQ_ALLOC] + sb.req_hits[REQ_SLAB_FREE] +
                 sb.req_hits[REQ_FREE] + sb.req_hits[REQ_INIT],
                 sb.req_hits[REQ_ALLOC], sb.req_hits[REQ_SLAB_FREE],
                 sb.req_hits[REQ_FREE], sb.req_hits[REQ_INIT]);
        $display("Checked %0d results: %0d ok, %0d not found, %0d exhausted, %0d full.",
                 sb.results_checked, sb.status_hits[ST_OK], sb.status_hits[ST_NOT_FOUND],
                 sb.status_hits[ST_EXHAUSTED], sb.status_hits[ST_FULL]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/spa_pkg.sv
rtl/core/spa_ram.sv
rtl/core/spa_engine.sv
rtl/core/slab_pool_allocator.sv
dv/slab_sb_pkg.sv
dv/tb_top.sv
